[hdl/ism_pkg.sv]
// Package for the interval set merge/insert block: sizes, codes, state
// encoding and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package ism_pkg;

    localparam int MAX_INTERVALS = 32;
    localparam int VAL_W         = 31;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CMP     = 5'b00010,
        S_UPD     = 5'b00100,
        S_ADD_RES = 5'b01000,
        S_READ    = 5'b10000
    } t_state;

    typedef struct packed {
        logic load_in;
        logic compare;
        logic update;
        logic emit_add;
        logic emit_entry;
        logic emit_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic rd_last;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic             status;
        logic             valid_res;
        logic [VAL_W-1:0] range_start;
        logic [VAL_W-1:0] range_end;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

[hdl/ism_in_if.sv]
// Input channel of the interval set block: valid/ready plus command and value.
// Depends on ism_pkg.
`default_nettype none

interface ism_in_if import ism_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [VAL_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

[hdl/ism_out_if.sv]
// Result channel of the interval set block: valid/ready plus result fields.
// Depends on ism_pkg.
`default_nettype none

interface ism_out_if import ism_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic             valid_res;
    logic [VAL_W-1:0] range_start;
    logic [VAL_W-1:0] range_end;
    logic             last;

    modport source (output valid, output status, output valid_res, output range_start,
                    output range_end, output last, input ready);
    modport sink   (input valid, input status, input valid_res, input range_start,
                    input range_end, input last, output ready);
endinterface

`default_nettype wire

[hdl/ism_ctrl.sv]
// Controller state machine of the interval set block: sequences accept,
// compare, update and result transactions. Depends on ism_pkg.
`default_nettype none

module ism_ctrl import ism_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_cmd,
    output logic          o_in_ready,
    output t_dp_cmd       o_dp_cmd,
    input  wire t_dp_stat i_dp_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_dp_cmd.load_in = 1'b1;
                    n_state = (i_in_cmd == CMD_READ) ? S_READ : S_CMP;
                end
            end
            S_CMP: begin
                o_dp_cmd.compare = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_dp_cmd.update = 1'b1;
                n_state = S_ADD_RES;
            end
            S_ADD_RES: begin
                if (i_dp_stat.out_free) begin
                    o_dp_cmd.emit_add = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                // hold until the result register can take the next transaction
                if (i_dp_stat.out_free) begin
                    if (i_dp_stat.cnt_zero) begin
                        o_dp_cmd.emit_empty = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_dp_cmd.emit_entry = 1'b1;
                        if (i_dp_stat.rd_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/ism_dp.sv]
// Datapath of the interval set block: row of interval cells with parallel
// compare, shift update, rotating readout and the result register. Depends on ism_pkg.
`default_nettype none

module ism_dp import ism_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_dp_cmd,
    input  wire logic [VAL_W-1:0] i_value,
    output t_dp_stat              o_dp_stat,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_result               o_result
);

    logic [VAL_W-1:0]         r_lo [MAX_INTERVALS];
    logic [VAL_W-1:0]         r_hi [MAX_INTERVALS];
    logic [VAL_W-1:0]         n_lo [MAX_INTERVALS];
    logic [VAL_W-1:0]         n_hi [MAX_INTERVALS];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CNT_W-1:0]         r_rd_cnt;
    logic [VAL_W-1:0]         r_value;
    logic [MAX_INTERVALS-1:0] r_below;
    logic [MAX_INTERVALS-1:0] r_merge;
    logic                     r_full;
    logic                     r_out_valid;
    t_result                  r_out;

    logic [MAX_INTERVALS-1:0] w_live;
    logic [MAX_INTERVALS-1:0] w_below;
    logic [MAX_INTERVALS-1:0] w_merge;
    logic [MAX_INTERVALS-1:0] w_prev_below;
    logic [MAX_INTERVALS-1:0] w_next_merge;
    logic [VAL_W-1:0]         w_up_lo [MAX_INTERVALS];
    logic [VAL_W-1:0]         w_up_hi [MAX_INTERVALS];
    logic [VAL_W-1:0]         w_dn_lo [MAX_INTERVALS];
    logic [VAL_W-1:0]         w_dn_hi [MAX_INTERVALS];
    logic                     w_any_merge;
    logic                     w_two_merge;
    logic                     w_full;
    logic                     w_rd_last;

    // neighbor taps: cell below (zero at the bottom), cell above (wraps to cell 0)
    for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_nbr
        if (g == 0) begin : g_first
            assign w_up_lo[g]      = '0;
            assign w_up_hi[g]      = '0;
            assign w_prev_below[g] = 1'b1;
        end else begin : g_rest
            assign w_up_lo[g]      = r_lo[g-1];
            assign w_up_hi[g]      = r_hi[g-1];
            assign w_prev_below[g] = r_below[g-1];
        end
        if (g == MAX_INTERVALS - 1) begin : g_top
            assign w_dn_lo[g]      = r_lo[0];
            assign w_dn_hi[g]      = r_hi[0];
            assign w_next_merge[g] = 1'b0;
        end else begin : g_mid
            assign w_dn_lo[g]      = r_lo[g+1];
            assign w_dn_hi[g]      = r_hi[g+1];
            assign w_next_merge[g] = r_merge[g+1];
        end
    end

    // every cell compares against the value at once
    always_comb begin
        for (int i = 0; i < MAX_INTERVALS; i++) begin
            w_live[i]  = (CNT_W'(i) < r_count);
            w_below[i] = w_live[i] && (({1'b0, r_hi[i]} + 32'd1) < {1'b0, r_value});
            w_merge[i] = w_live[i] && !w_below[i]
                         && ({1'b0, r_lo[i]} <= ({1'b0, r_value} + 32'd1));
        end
    end

    assign w_any_merge = |r_merge;
    assign w_two_merge = |(r_merge[MAX_INTERVALS-2:0] & r_merge[MAX_INTERVALS-1:1]);
    assign w_full      = !w_any_merge && (r_count == CNT_W'(MAX_INTERVALS));
    assign w_rd_last   = (r_rd_cnt == (r_count - CNT_W'(1)));

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_count = r_count;
        if (i_dp_cmd.update) begin
            if (!w_any_merge) begin
                // open a gap at the insert point, drop on a full table
                if (!w_full) begin
                    n_count = r_count + CNT_W'(1);
                    for (int i = 0; i < MAX_INTERVALS; i++) begin
                        if (!r_below[i]) begin
                            if (w_prev_below[i]) begin
                                n_lo[i] = r_value;
                                n_hi[i] = r_value;
                            end else begin
                                n_lo[i] = w_up_lo[i];
                                n_hi[i] = w_up_hi[i];
                            end
                        end
                    end
                end
            end else if (!w_two_merge) begin
                for (int i = 0; i < MAX_INTERVALS; i++) begin
                    if (r_merge[i]) begin
                        if (r_value < r_lo[i]) n_lo[i] = r_value;
                        if (r_value > r_hi[i]) n_hi[i] = r_value;
                    end
                end
            end else begin
                // value bridges two cells: join them and close the gap
                n_count = r_count - CNT_W'(1);
                for (int i = 0; i < MAX_INTERVALS; i++) begin
                    if (!r_below[i]) begin
                        if (r_merge[i] && w_next_merge[i]) begin
                            n_hi[i] = w_dn_hi[i];
                        end else begin
                            n_lo[i] = w_dn_lo[i];
                            n_hi[i] = w_dn_hi[i];
                        end
                    end
                end
            end
        end else if (i_dp_cmd.emit_entry) begin
            // rotate the live cells by one; after count steps the row is restored
            for (int i = 0; i < MAX_INTERVALS; i++) begin
                if (CNT_W'(i) == (r_count - CNT_W'(1))) begin
                    n_lo[i] = r_lo[0];
                    n_hi[i] = r_hi[0];
                end else begin
                    n_lo[i] = w_dn_lo[i];
                    n_hi[i] = w_dn_hi[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (i_dp_cmd.load_in) begin
            r_value <= i_value;
        end
        if (i_dp_cmd.compare) begin
            r_below <= w_below;
            r_merge <= w_merge;
        end
        if (i_dp_cmd.update) begin
            r_full <= w_full;
        end
        if (i_dp_cmd.emit_add) begin
            r_out <= '{status: r_full, valid_res: 1'b0, range_start: '0,
                       range_end: '0, last: 1'b1};
        end else if (i_dp_cmd.emit_empty) begin
            r_out <= '{status: ST_OK, valid_res: 1'b0, range_start: '0,
                       range_end: '0, last: 1'b1};
        end else if (i_dp_cmd.emit_entry) begin
            r_out <= '{status: ST_OK, valid_res: 1'b1, range_start: r_lo[0],
                       range_end: r_hi[0], last: w_rd_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_dp_cmd.load_in) begin
                r_rd_cnt <= '0;
            end else if (i_dp_cmd.emit_entry) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
            if (i_dp_cmd.emit_add || i_dp_cmd.emit_empty || i_dp_cmd.emit_entry) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_dp_stat.cnt_zero = (r_count == '0);
    assign o_dp_stat.rd_last  = w_rd_last;
    assign o_dp_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_result           = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_INTERVALS))
        else $error("interval count above table size");

    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.valid_res) |-> (r_out.status == ST_OK))
        else $error("interval result carries full status");

    // the row is in sorted order except part way through a readout rotation
    for (genvar g = 0; g < MAX_INTERVALS - 1; g++) begin : g_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (((r_rd_cnt == '0) || (r_rd_cnt == r_count)) && (CNT_W'(g + 1) < r_count)) |->
                ({1'b0, r_lo[g+1]} >= ({1'b0, r_hi[g]} + 32'd2)))
            else $error("stored intervals not sorted and separated");
    end

    for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_ord
        a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (CNT_W'(g) < r_count) |-> (r_lo[g] <= r_hi[g]))
            else $error("stored interval with lower bound above upper bound");
    end
`endif

endmodule

`default_nettype wire

[hdl/interval_set_merge_insert_top.sv]
// Top level of the interval set merge/insert block: joins the controller and
// the datapath to the input and result channels. Depends on ism_pkg, ism_in_if,
// ism_out_if, ism_ctrl and ism_dp.
//
// Keeps up to MAX_INTERVALS sorted, disjoint, non-adjacent intervals in a row
// of cells. An add transaction steps through accept, one compare of the value
// against all cells at once, one shift/merge update of the row, and the status
// result, which waits while a stalled sink still holds the output register;
// the next input is taken in the cycle after the result is loaded into
// the output register. A read transaction gives one result per stored interval
// (one empty result for an empty table): the row rotates one cell per cycle past
// cell 0, which feeds the single output register, while the sink is ready.
// Cells need no reset; only the count, read counter and output valid are.
`default_nettype none

module interval_set_merge_insert_top import ism_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ism_in_if.sink     i_in,
    ism_out_if.source  o_out
);

    t_dp_cmd  w_dp_cmd;
    t_dp_stat w_dp_stat;
    t_result  w_result;
    logic     w_in_ready;
    logic     w_out_valid;

    ism_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (w_in_ready),
        .o_dp_cmd   (w_dp_cmd),
        .i_dp_stat  (w_dp_stat)
    );

    ism_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_cmd    (w_dp_cmd),
        .i_value     (i_in.value),
        .o_dp_stat   (w_dp_stat),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_result    (w_result)
    );

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = w_out_valid;
    assign o_out.status      = w_result.status;
    assign o_out.valid_res   = w_result.valid_res;
    assign o_out.range_start = w_result.range_start;
    assign o_out.range_end   = w_result.range_end;
    assign o_out.last        = w_result.last;

endmodule

`default_nettype wire
